@@ hw/rtl/lcg_modexp_random_id_generator_defines.svh @@
// Assertion macros shared by the RTL files.
`ifndef LCG_MODEXP_RANDOM_ID_GENERATOR_DEFINES_SVH
`define LCG_MODEXP_RANDOM_ID_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define LCGME_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LCGME_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define LCGME_ASSERT(lbl, clk, rstn, prop, msg)
`define LCGME_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hw/rtl/lcgme_pkg.sv @@
`timescale 1ns / 1ps
package lcgme_pkg;

    localparam int unsigned MM_PROD_W = 64;
    localparam int unsigned MM_CNT_W  = $clog2(MM_PROD_W);

    localparam logic [30:0] RST_PRIME_MOD  = 31'd2147483629;
    localparam logic [30:0] RST_LCG_MOD    = 31'd1836660096;
    localparam logic [30:0] RST_CYCLE_LIM  = 31'd1000000000;
    localparam logic [30:0] RST_BASE_GEN   = 31'd2;
    localparam logic [30:0] RST_LCG_BASE   = 31'd7;
    localparam logic [15:0] RST_RESEED_SEC = 16'd180;
    localparam logic [30:0] RST_LARGE_FAC  = 31'd59652323;
    localparam logic [31:0] RST_OUT_MASK   = 32'hffff_ffff;

    localparam logic [5:0]  INC_TRIES      = 6'd4;
    localparam logic [5:0]  COPRIME_STEPS  = 6'd32;

    typedef enum logic [3:0] {
        CFG_PRIME_MOD  = 4'd0,
        CFG_LCG_MOD    = 4'd1,
        CFG_CYCLE_LIM  = 4'd2,
        CFG_BASE_GEN   = 4'd3,
        CFG_LCG_BASE   = 4'd4,
        CFG_RESEED_SEC = 4'd5,
        CFG_LARGE_FAC  = 4'd6,
        CFG_OUT_MASK   = 4'd7
    } cfg_idx_e;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK1,
        ST_CHECK2,
        ST_RS_SEED,
        ST_RS_SEED_R,
        ST_RS_INC,
        ST_RS_MULT_R,
        ST_RS_J_R,
        ST_RS_TST,
        ST_RS_TL_R,
        ST_RS_JINC,
        ST_RS_JINC_R,
        ST_RS_GEN,
        ST_RS_GEN_R,
        ST_STEP,
        ST_STEP_R,
        ST_PW_LOOP,
        ST_PW_ACC_R,
        ST_PW_SQ,
        ST_PW_SQ_R,
        ST_WAIT,
        ST_FIN
    } state_t;

    // (a * b + c) mod m, optionally on the low 32 bits of the sum
    typedef struct packed {
        logic        start;
        logic        trunc32;
        logic [31:0] a;
        logic [30:0] b;
        logic [31:0] c;
        logic [30:0] m;
    } mm_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [30:0] r;
    } mm_rsp_t;

endpackage

@@ hw/rtl/lcgme_mulmod.sv @@
`timescale 1ns / 1ps
`include "lcg_modexp_random_id_generator_defines.svh"
module lcgme_mulmod (
    input  logic               aclk,
    input  logic               aresetn,
    input  lcgme_pkg::mm_req_t req,
    output lcgme_pkg::mm_rsp_t rsp
);
    logic                            busy_reg;
    logic                            done_reg;
    logic [lcgme_pkg::MM_CNT_W-1:0]  cnt_reg;
    logic [lcgme_pkg::MM_PROD_W-1:0] prod_reg;
    logic [30:0]                     rem_reg;
    logic [30:0]                     mod_reg;

    logic [lcgme_pkg::MM_PROD_W-1:0] sum;
    logic [lcgme_pkg::MM_PROD_W-1:0] prod_in;
    logic [31:0]                     trial;
    logic                            ge;
    logic [30:0]                     rem_next;

    always_comb begin
        sum     = lcgme_pkg::MM_PROD_W'(req.a) * lcgme_pkg::MM_PROD_W'(req.b)
                + lcgme_pkg::MM_PROD_W'(req.c);
        prod_in = req.trunc32 ? lcgme_pkg::MM_PROD_W'(sum[31:0]) : sum;
        trial   = {rem_reg, prod_reg[lcgme_pkg::MM_PROD_W-1]};
        ge      = trial >= {1'b0, mod_reg};
        rem_next = ge ? 31'(trial - {1'b0, mod_reg}) : trial[30:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                prod_reg <= prod_in;
                rem_reg  <= '0;
                mod_reg  <= req.m;
            end else if (busy_reg) begin
                prod_reg <= prod_reg << 1;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == lcgme_pkg::MM_CNT_W'(lcgme_pkg::MM_PROD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // zero modulus reduces to zero
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.r    = (mod_reg == '0) ? '0 : rem_reg;

    `LCGME_ASSERT_IMPL(a_rem_below_mod, aclk, aresetn, done_reg && mod_reg != '0, rsp.r < mod_reg, "remainder not below modulus")
    `LCGME_ASSERT_IMPL(a_done_after_busy, aclk, aresetn, done_reg, $past(busy_reg), "done without a pass")
    `LCGME_ASSERT_IMPL(a_done_single, aclk, aresetn, done_reg, !busy_reg || $past(req.start), "done while still running")
endmodule

@@ hw/rtl/lcg_modexp_random_id_generator.sv @@
`timescale 1ns / 1ps
`include "lcg_modexp_random_id_generator_defines.svh"
// Non-repeating random id generator. One request is taken at a time: s_tready is low from the
// transfer until the id has been loaded into the output register. All modular products and
// reductions by the configured moduli go through one multiply-and-reduce unit, which loads the
// product and then reduces it bit-serially over its 64 bits before handing the result back. A
// request without reseed costs skip_random+1 LCG steps plus one modular power of up to 30
// squarings and 31 multiplies. A reseed adds two further powers, up to 66 reductions for the
// start value, j and the coprime search, and up to five checks on the increment, which are done
// outside the unit.
module lcg_modexp_random_id_generator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_seconds[31:0], skip_random[33:32], rand_start[65:34], rand_seed[97:66],
    // rand_seed2[129:98], rand_inc[161:130], rand_mult_exp[193:162], rand_gen_exp[225:194]
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // random_id[31:0], reseeded[32]
    output logic [39:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    // configuration
    logic [30:0] prime_mod_reg, lcg_mod_reg, cycle_lim_reg, base_gen_reg;
    logic [30:0] lcg_base_reg, large_fac_reg;
    logic [15:0] reseed_sec_reg;
    logic [31:0] out_mask_reg;

    // request
    logic [31:0] now_reg, rstart_reg, rseed_reg, rseed2_reg, rinc_reg, rmexp_reg, rgexp_reg;
    logic [1:0]  skip_reg;

    // generator state
    logic [30:0] lcg_value_reg, lcg_value_next;
    logic [30:0] xor_seed_reg, xor_seed_next;
    logic [30:0] exp_seed_reg, exp_seed_next;
    logic [31:0] lcg_mult_reg, lcg_mult_next;
    logic [31:0] lcg_inc_reg, lcg_inc_next;
    logic [30:0] cur_gen_reg, cur_gen_next;
    logic [31:0] count_reg, count_next;
    logic        top_reg, top_next;
    logic [32:0] deadline_reg, deadline_next;

    // sequencer
    lcgme_pkg::state_t state_reg, state_next;
    lcgme_pkg::state_t ret_reg, ret_next;
    lcgme_pkg::state_t pw_ret_reg, pw_ret_next;
    logic        phase_reg, phase_next;
    logic        did_reg, did_next;
    logic [5:0]  k_reg, k_next;
    logic [1:0]  step_reg, step_next;
    logic [30:0] j_reg, j_next;
    logic [30:0] acc_reg, acc_next;
    logic [30:0] sq_reg, sq_next;
    logic [31:0] e_reg, e_next;
    logic [30:0] pm_reg, pm_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] id_reg, id_next;
    logic        rsd_reg, rsd_next;

    lcgme_pkg::mm_req_t mm_req;
    lcgme_pkg::mm_rsp_t mm_rsp;

    logic        s_xfer;
    logic [31:0] ahead;

    // remainder by three from the base-4 digit sum
    function automatic logic [1:0] mod3(input logic [31:0] v);
        logic [5:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < 16; i++) begin
            s = s + 6'(v[2*i +: 2]);
        end
        t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
        u = 3'(t[1:0]) + 3'(t[3:2]);
        return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
    endfunction

    lcgme_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    assign s_tready  = (state_reg == lcgme_pkg::ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'd0, rsd_reg, id_reg};
    assign ahead     = count_reg + 32'(skip_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_mod_reg  <= lcgme_pkg::RST_PRIME_MOD;
            lcg_mod_reg    <= lcgme_pkg::RST_LCG_MOD;
            cycle_lim_reg  <= lcgme_pkg::RST_CYCLE_LIM;
            base_gen_reg   <= lcgme_pkg::RST_BASE_GEN;
            lcg_base_reg   <= lcgme_pkg::RST_LCG_BASE;
            reseed_sec_reg <= lcgme_pkg::RST_RESEED_SEC;
            large_fac_reg  <= lcgme_pkg::RST_LARGE_FAC;
            out_mask_reg   <= lcgme_pkg::RST_OUT_MASK;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lcgme_pkg::CFG_PRIME_MOD:  prime_mod_reg  <= cfg_data[30:0];
                lcgme_pkg::CFG_LCG_MOD:    lcg_mod_reg    <= cfg_data[30:0];
                lcgme_pkg::CFG_CYCLE_LIM:  cycle_lim_reg  <= cfg_data[30:0];
                lcgme_pkg::CFG_BASE_GEN:   base_gen_reg   <= cfg_data[30:0];
                lcgme_pkg::CFG_LCG_BASE:   lcg_base_reg   <= cfg_data[30:0];
                lcgme_pkg::CFG_RESEED_SEC: reseed_sec_reg <= cfg_data[15:0];
                lcgme_pkg::CFG_LARGE_FAC:  large_fac_reg  <= cfg_data[30:0];
                lcgme_pkg::CFG_OUT_MASK:   out_mask_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            now_reg    <= s_tdata[31:0];
            skip_reg   <= s_tdata[33:32];
            rstart_reg <= s_tdata[65:34];
            rseed_reg  <= s_tdata[97:66];
            rseed2_reg <= s_tdata[129:98];
            rinc_reg   <= s_tdata[161:130];
            rmexp_reg  <= s_tdata[193:162];
            rgexp_reg  <= s_tdata[225:194];
        end
        ret_reg    <= ret_next;
        pw_ret_reg <= pw_ret_next;
        phase_reg  <= phase_next;
        did_reg    <= did_next;
        k_reg      <= k_next;
        step_reg   <= step_next;
        j_reg      <= j_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        e_reg      <= e_next;
        pm_reg     <= pm_next;
        id_reg     <= id_next;
        rsd_reg    <= rsd_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lcgme_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            lcg_value_reg <= '0;
            xor_seed_reg  <= '0;
            exp_seed_reg  <= '0;
            lcg_mult_reg  <= '0;
            lcg_inc_reg   <= '0;
            cur_gen_reg   <= '0;
            count_reg     <= '0;
            top_reg       <= 1'b0;
            deadline_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            lcg_value_reg <= lcg_value_next;
            xor_seed_reg  <= xor_seed_next;
            exp_seed_reg  <= exp_seed_next;
            lcg_mult_reg  <= lcg_mult_next;
            lcg_inc_reg   <= lcg_inc_next;
            cur_gen_reg   <= cur_gen_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            deadline_reg  <= deadline_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        pw_ret_next    = pw_ret_reg;
        phase_next     = phase_reg;
        did_next       = did_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        j_next         = j_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        e_next         = e_reg;
        pm_next        = pm_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        id_next        = id_reg;
        rsd_next       = rsd_reg;
        lcg_value_next = lcg_value_reg;
        xor_seed_next  = xor_seed_reg;
        exp_seed_next  = exp_seed_reg;
        lcg_mult_next  = lcg_mult_reg;
        lcg_inc_next   = lcg_inc_reg;
        cur_gen_next   = cur_gen_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        deadline_next  = deadline_reg;
        mm_req         = '0;

        unique case (state_reg)
            lcgme_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    did_next   = 1'b0;
                    state_next = lcgme_pkg::ST_CHECK1;
                end
            end
            lcgme_pkg::ST_CHECK1: begin
                phase_next = 1'b0;
                if (count_reg >= {1'b0, cycle_lim_reg} || {1'b0, now_reg} > deadline_reg) begin
                    state_next = lcgme_pkg::ST_RS_SEED;
                end else begin
                    state_next = lcgme_pkg::ST_CHECK2;
                end
            end
            lcgme_pkg::ST_CHECK2: begin
                phase_next = 1'b1;
                step_next  = '0;
                if (ahead >= {1'b0, cycle_lim_reg}) begin
                    state_next = lcgme_pkg::ST_RS_SEED;
                end else begin
                    state_next = lcgme_pkg::ST_STEP;
                end
            end
            lcgme_pkg::ST_RS_SEED: begin
                xor_seed_next = rseed_reg[30:0];
                exp_seed_next = rseed2_reg[30:0];
                lcg_inc_next  = rinc_reg | 32'd1;
                k_next        = '0;
                mm_req.start  = 1'b1;
                mm_req.a      = rstart_reg;
                mm_req.b      = 31'd1;
                mm_req.m      = lcg_mod_reg;
                ret_next      = lcgme_pkg::ST_RS_SEED_R;
                state_next    = lcgme_pkg::ST_WAIT;
            end
            lcgme_pkg::ST_RS_SEED_R: begin
                lcg_value_next = mm_rsp.r;
                state_next     = lcgme_pkg::ST_RS_INC;
            end
            lcgme_pkg::ST_RS_INC: begin
                if (mod3(lcg_inc_reg) == 2'd0 && k_reg < lcgme_pkg::INC_TRIES) begin
                    lcg_inc_next = lcg_inc_reg + 32'd2;
                    k_next       = k_reg + 6'd1;
                end else begin
                    acc_next    = 31'd1;
                    sq_next     = lcg_base_reg;
                    e_next      = {rmexp_reg[31:1], 1'b0};
                    pm_next     = lcg_mod_reg;
                    pw_ret_next = lcgme_pkg::ST_RS_MULT_R;
                    state_next  = lcgme_pkg::ST_PW_LOOP;
                end
            end
            lcgme_pkg::ST_RS_MULT_R: begin
                lcg_mult_next = {1'b0, acc_reg};
                mm_req.start  = 1'b1;
                mm_req.a      = rgexp_reg;
                mm_req.b      = 31'd1;
                mm_req.m      = prime_mod_reg;
                ret_next      = lcgme_pkg::ST_RS_J_R;
                state_next    = lcgme_pkg::ST_WAIT;
            end
            lcgme_pkg::ST_RS_J_R: begin
                j_next     = mm_rsp.r;
                k_next     = '0;
                state_next = lcgme_pkg::ST_RS_TST;
            end
            lcgme_pkg::ST_RS_TST: begin
                if (k_reg == lcgme_pkg::COPRIME_STEPS) begin
                    state_next = lcgme_pkg::ST_RS_GEN;
                end else if (!j_reg[0] || mod3({1'b0, j_reg}) == 2'd0) begin
                    state_next = lcgme_pkg::ST_RS_JINC;
                end else if (large_fac_reg != '0) begin
                    mm_req.start = 1'b1;
                    mm_req.a     = {1'b0, j_reg};
                    mm_req.b     = 31'd1;
                    mm_req.m     = large_fac_reg;
                    ret_next     = lcgme_pkg::ST_RS_TL_R;
                    state_next   = lcgme_pkg::ST_WAIT;
                end else begin
                    state_next = lcgme_pkg::ST_RS_GEN;
                end
            end
            lcgme_pkg::ST_RS_TL_R: begin
                state_next = (mm_rsp.r == '0) ? lcgme_pkg::ST_RS_JINC : lcgme_pkg::ST_RS_GEN;
            end
            lcgme_pkg::ST_RS_JINC: begin
                mm_req.start = 1'b1;
                mm_req.a     = {1'b0, j_reg};
                mm_req.b     = 31'd1;
                mm_req.c     = 32'd1;
                mm_req.m     = prime_mod_reg;
                ret_next     = lcgme_pkg::ST_RS_JINC_R;
                state_next   = lcgme_pkg::ST_WAIT;
            end
            lcgme_pkg::ST_RS_JINC_R: begin
                j_next     = mm_rsp.r;
                k_next     = k_reg + 6'd1;
                state_next = lcgme_pkg::ST_RS_TST;
            end
            lcgme_pkg::ST_RS_GEN: begin
                acc_next    = 31'd1;
                sq_next     = base_gen_reg;
                e_next      = {1'b0, j_reg};
                pm_next     = prime_mod_reg;
                pw_ret_next = lcgme_pkg::ST_RS_GEN_R;
                state_next  = lcgme_pkg::ST_PW_LOOP;
            end
            lcgme_pkg::ST_RS_GEN_R: begin
                cur_gen_next  = acc_reg;
                count_next    = '0;
                deadline_next = {1'b0, now_reg} + 33'(reseed_sec_reg);
                top_next      = !top_reg;
                did_next      = 1'b1;
                state_next    = phase_reg ? lcgme_pkg::ST_STEP : lcgme_pkg::ST_CHECK2;
            end
            lcgme_pkg::ST_STEP: begin
                mm_req.start   = 1'b1;
                mm_req.trunc32 = 1'b1;
                mm_req.a       = lcg_mult_reg;
                mm_req.b       = lcg_value_reg;
                mm_req.c       = lcg_inc_reg;
                mm_req.m       = lcg_mod_reg;
                ret_next       = lcgme_pkg::ST_STEP_R;
                state_next     = lcgme_pkg::ST_WAIT;
            end
            lcgme_pkg::ST_STEP_R: begin
                lcg_value_next = mm_rsp.r;
                if (step_reg == skip_reg) begin
                    count_next  = count_reg + 32'(skip_reg) + 32'd1;
                    acc_next    = 31'd1;
                    sq_next     = cur_gen_reg;
                    e_next      = {1'b0, exp_seed_reg ^ mm_rsp.r};
                    pm_next     = prime_mod_reg;
                    pw_ret_next = lcgme_pkg::ST_FIN;
                    state_next  = lcgme_pkg::ST_PW_LOOP;
                end else begin
                    step_next  = step_reg + 2'd1;
                    state_next = lcgme_pkg::ST_STEP;
                end
            end
            lcgme_pkg::ST_PW_LOOP: begin
                if (e_reg == '0) begin
                    state_next = pw_ret_reg;
                end else if (e_reg[0]) begin
                    mm_req.start = 1'b1;
                    mm_req.a     = {1'b0, acc_reg};
                    mm_req.b     = sq_reg;
                    mm_req.m     = pm_reg;
                    ret_next     = lcgme_pkg::ST_PW_ACC_R;
                    state_next   = lcgme_pkg::ST_WAIT;
                end else begin
                    state_next = lcgme_pkg::ST_PW_SQ;
                end
            end
            lcgme_pkg::ST_PW_ACC_R: begin
                acc_next   = mm_rsp.r;
                state_next = lcgme_pkg::ST_PW_SQ;
            end
            lcgme_pkg::ST_PW_SQ: begin
                e_next = e_reg >> 1;
                if (e_reg[31:1] == '0) begin
                    state_next = pw_ret_reg;
                end else begin
                    mm_req.start = 1'b1;
                    mm_req.a     = {1'b0, sq_reg};
                    mm_req.b     = sq_reg;
                    mm_req.m     = pm_reg;
                    ret_next     = lcgme_pkg::ST_PW_SQ_R;
                    state_next   = lcgme_pkg::ST_WAIT;
                end
            end
            lcgme_pkg::ST_PW_SQ_R: begin
                sq_next    = mm_rsp.r;
                state_next = lcgme_pkg::ST_PW_LOOP;
            end
            lcgme_pkg::ST_WAIT: begin
                if (mm_rsp.done) begin
                    state_next = ret_reg;
                end
            end
            lcgme_pkg::ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    id_next      = ({1'b0, xor_seed_reg ^ acc_reg} | {top_reg, 31'd0})
                                 & out_mask_reg;
                    rsd_next     = did_reg;
                    state_next   = lcgme_pkg::ST_IDLE;
                end
            end
            default: state_next = lcgme_pkg::ST_IDLE;
        endcase
    end

    `LCGME_ASSERT(a_busy_after_take, aclk, aresetn, s_xfer |=> !s_tready, "ready right after a transfer")
    `LCGME_ASSERT_IMPL(a_start_when_idle, aclk, aresetn, mm_req.start, !mm_rsp.busy, "unit restarted while busy")
    `LCGME_ASSERT_IMPL(a_load_from_fin, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == lcgme_pkg::ST_FIN), "result loaded outside final step")
endmodule

@@ test/lcg_id_checker.sv @@
`timescale 1ns / 1ps
module lcg_id_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [231:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           errors,
    output int           pending,
    output int           ids_seen,
    output int           reseeds_seen
);

    typedef struct packed {
        bit        reseeded;
        bit [31:0] id;
    } id_rec_t;

    bit [30:0] n_mod, m_mod, lim, g0, a_base, big_fac;
    bit [15:0] rs_sec;
    bit [31:0] mask;

    bit [30:0] x_val, seed_x, seed_e, gen;
    bit [31:0] mult, inc, issued;
    bit        flip;
    bit [32:0] deadline;

    id_rec_t   id_q[$];

    assign pending = id_q.size();

    function automatic bit [31:0] md(longint unsigned v, bit [31:0] m);
        if (m == 0)
            return 0;
        return 32'(v % m);
    endfunction

    function automatic bit [31:0] pw(bit [31:0] g, bit [31:0] e, bit [31:0] m);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1;
        sq  = g;
        while (e != 0) begin
            if (e[0])
                acc = md(acc * sq, m);
            e  = e >> 1;
            sq = md(sq * sq, m);
        end
        return acc[31:0];
    endfunction

    function automatic bit has_factor(bit [31:0] j);
        if (j % 2 == 0 || j % 3 == 0)
            return 1;
        return big_fac != 0 && j % big_fac == 0;
    endfunction

    task automatic reseed_state(bit [31:0] now, bit [31:0] w_start, bit [31:0] w_seed,
                                bit [31:0] w_seed2, bit [31:0] w_inc, bit [31:0] w_mexp,
                                bit [31:0] w_gexp);
        bit [31:0] j;
        x_val  = 31'(md(w_start, m_mod));
        seed_x = w_seed[30:0];
        seed_e = w_seed2[30:0];
        inc    = w_inc | 32'd1;
        mult   = pw(a_base, w_mexp & ~32'd1, m_mod);
        for (int k = 0; k < 4 && inc % 3 == 0; k++)
            inc = inc + 32'd2;
        j = md(w_gexp, n_mod);
        for (int k = 0; k < 32 && has_factor(j); k++)
            j = md(longint'(j) + 1, n_mod);
        gen      = 31'(pw(g0, j, n_mod));
        issued   = 0;
        deadline = {1'b0, now} + rs_sec;
        flip     = ~flip;
    endtask

    task automatic compute_id(bit [231:0] d, output id_rec_t r);
        bit [31:0] now;
        bit [1:0]  skip;
        bit [31:0] t;
        bit [31:0] p;
        bit        did;
        now  = d[31:0];
        skip = d[33:32];
        did  = 0;
        if (issued >= lim || {1'b0, now} > deadline) begin
            reseed_state(now, d[65:34], d[97:66], d[129:98], d[161:130], d[193:162],
                         d[225:194]);
            did = 1;
        end
        if (issued + skip >= {1'b0, lim}) begin
            reseed_state(now, d[65:34], d[97:66], d[129:98], d[161:130], d[193:162],
                         d[225:194]);
            did = 1;
        end
        for (int i = 0; i <= skip; i++) begin
            t     = mult * {1'b0, x_val} + inc;
            x_val = 31'(md(t, m_mod));
        end
        issued = issued + skip + 32'd1;
        p = pw(gen, seed_e ^ x_val, n_mod);
        r.id       = (({1'b0, seed_x} ^ p) | {flip, 31'b0}) & mask;
        r.reseeded = did;
    endtask

    always @(posedge aclk) begin
        id_rec_t want;
        id_rec_t got;
        if (!aresetn) begin
            n_mod   = lcgme_pkg::RST_PRIME_MOD;
            m_mod   = lcgme_pkg::RST_LCG_MOD;
            lim     = lcgme_pkg::RST_CYCLE_LIM;
            g0      = lcgme_pkg::RST_BASE_GEN;
            a_base  = lcgme_pkg::RST_LCG_BASE;
            rs_sec  = lcgme_pkg::RST_RESEED_SEC;
            big_fac = lcgme_pkg::RST_LARGE_FAC;
            mask    = lcgme_pkg::RST_OUT_MASK;
            x_val = 0; seed_x = 0; seed_e = 0; gen = 0;
            mult = 0; inc = 0; issued = 0; flip = 0; deadline = 0;
            errors = 0; ids_seen = 0; reseeds_seen = 0;
            id_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (lcgme_pkg::cfg_idx_e'(cfg_index))
                    lcgme_pkg::CFG_PRIME_MOD:  n_mod   = cfg_data[30:0];
                    lcgme_pkg::CFG_LCG_MOD:    m_mod   = cfg_data[30:0];
                    lcgme_pkg::CFG_CYCLE_LIM:  lim     = cfg_data[30:0];
                    lcgme_pkg::CFG_BASE_GEN:   g0      = cfg_data[30:0];
                    lcgme_pkg::CFG_LCG_BASE:   a_base  = cfg_data[30:0];
                    lcgme_pkg::CFG_RESEED_SEC: rs_sec  = cfg_data[15:0];
                    lcgme_pkg::CFG_LARGE_FAC:  big_fac = cfg_data[30:0];
                    lcgme_pkg::CFG_OUT_MASK:   mask    = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.id       = m_tdata[31:0];
                got.reseeded = m_tdata[32];
                ids_seen++;
                if (got.reseeded)
                    reseeds_seen++;
                if (id_q.size() == 0) begin
                    $error("unexpected result transfer: random_id %h", got.id);
                    errors++;
                end else begin
                    want = id_q.pop_front();
                    if (got.id !== want.id) begin
                        $error("random_id: expected %h, got %h", want.id, got.id);
                        errors++;
                    end
                    if (got.reseeded !== want.reseeded) begin
                        $error("reseeded: expected %0d, got %0d", want.reseeded,
                               got.reseeded);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                compute_id(s_tdata, want);
                id_q.push_back(want);
            end
        end
    end

endmodule

@@ test/tb_lcg_modexp_random_id_generator.sv @@
`timescale 1ns / 1ps
module tb_lcg_modexp_random_id_generator;

    localparam longint CYCLE_LIMIT = 64'd250_000_000;

    logic         aclk      = 0;
    logic         aresetn   = 0;
    logic         s_tvalid  = 0;
    logic         s_tready;
    logic [231:0] s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 0;
    logic [39:0]  m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [3:0]   cfg_index = '0;
    logic [31:0]  cfg_data  = '0;

    int errors, pending, ids_seen, reseeds_seen;
    bit hold_req  = 0;
    bit hold_done = 0;
    bit quiet     = 0;
    bit [31:0] sec = 0;
    int items_sent = 0;
    longint cycles = 0;

    always #5 aclk = ~aclk;

    lcg_modexp_random_id_generator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lcg_id_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending),
        .ids_seen(ids_seen), .reseeds_seen(reseeds_seen)
    );

    function automatic int pick_gap(bit no_gap);
        int r;
        r = $urandom_range(0, 99);
        if (no_gap || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 0;
                repeat (30000) @(posedge aclk);
                hold_done = 1;
            end else begin
                gap = pick_gap(quiet);
                if (gap > 0) begin
                    m_tready <= 0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_req(bit [31:0] now, bit [1:0] skip, bit [31:0] w_start,
                            bit [31:0] w_seed, bit [31:0] w_seed2, bit [31:0] w_inc,
                            bit [31:0] w_mexp, bit [31:0] w_gexp);
        int gap;
        s_tdata  <= {6'd0, w_gexp, w_mexp, w_inc, w_seed2, w_seed, w_start, skip, now};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        gap = pick_gap(quiet);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic cfg_write(lcgme_pkg::cfg_idx_e idx, bit [31:0] value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic cfg_all(bit [31:0] pm, bit [31:0] lm, bit [31:0] cl, bit [31:0] bg,
                           bit [31:0] lb, bit [31:0] rs, bit [31:0] lf, bit [31:0] om);
        settle();
        cfg_write(lcgme_pkg::CFG_PRIME_MOD, pm);
        cfg_write(lcgme_pkg::CFG_LCG_MOD, lm);
        cfg_write(lcgme_pkg::CFG_CYCLE_LIM, cl);
        cfg_write(lcgme_pkg::CFG_BASE_GEN, bg);
        cfg_write(lcgme_pkg::CFG_LCG_BASE, lb);
        cfg_write(lcgme_pkg::CFG_RESEED_SEC, rs);
        cfg_write(lcgme_pkg::CFG_LARGE_FAC, lf);
        cfg_write(lcgme_pkg::CFG_OUT_MASK, om);
    endtask

    task automatic run_random(int count);
        bit [31:0] seed2;
        int r;
        for (int i = 0; i < count; i++) begin
            quiet = (i % 100) < 15;
            r = $urandom_range(0, 99);
            if (r < 85)
                sec = sec + $urandom_range(0, 3);
            else if (r < 93)
                sec = $urandom;
            else
                sec = sec + $urandom_range(100, 70000);
            seed2 = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 255);
            send_req(sec, 2'($urandom_range(0, 3)), $urandom, $urandom, seed2, $urandom,
                     $urandom, $urandom);
        end
        quiet = 0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // zero state first, then timed reseed, skips, word extremes
        send_req(0, 0, 0, 0, 0, 0, 0, 0);
        send_req(1, 0, 0, 0, 0, 0, 0, 0);
        send_req(1, 3, '1, '1, '1, '1, '1, '1);
        send_req(2, 1, 5, 7, 9, 2, 3, 4);
        send_req(181, 2, '1, '1, '1, 32'hffff_ffff, '1, '1);
        send_req(182, 0, 1, 2, 3, 32'd8, 32'd1, 32'd2147483629);
        send_req(400, 3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd14,
                 32'h8000_0000, 32'd2147483628);
        send_req(400, 0, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                 32'h5555_5555, 32'haaaa_aaaa);
        send_req(32'hffff_ffff, 1, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
        send_req(32'hffff_ffff, 3, 0, 0, 0, 0, 0, 0);
        send_req(0, 2, $urandom, $urandom, $urandom, 32'd20, $urandom, 32'd59652323);
        for (int i = 0; i < 9; i++)
            send_req(32'd1000 + i, 2'(i), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        sec = 1000;

        hold_req = 1;
        run_random(300);

        cfg_all(101, 97, 4, 3, 2, 0, 5, 32'h000f_ffff);
        run_random(350);

        cfg_all(32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 2,
                32'hffff_ffff, 2, 0);
        run_random(300);

        cfg_all(5, 2, 4, 2, 2, 1, 2, 32'h8000_0001);
        run_random(300);

        for (int p = 0; p < 2; p++) begin
            cfg_all($urandom_range(5, 32'h7fff_ffff), $urandom_range(2, 32'h7fff_ffff),
                    $urandom_range(4, 2000), $urandom_range(2, 32'h7fff_ffff),
                    $urandom_range(2, 32'h7fff_ffff), $urandom_range(0, 400),
                    $urandom_range(2, 32'h7fff_ffff), $urandom);
            run_random(190);
        end

        settle();
        repeat (5000) @(posedge aclk);
        $display("Run covered %0d requests and %0d ids, %0d of them after a reseed,",
                 items_sent, ids_seen, reseeds_seen);
        $display("across default, small, extreme and random register settings.");
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
